FILE: rtl/rxid_pkg.sv
// shared types, constants and helpers for the run-length row-xor image decoder
// no dependencies; imported by rxid_ctrl, rxid_datapath and the top level
package rxid_pkg;

  // default sizes handed to the top level parameters
  localparam int DEF_MAX_WIDTH         = 256;
  localparam int DEF_MAX_HEIGHT        = 256;
  localparam int DEF_PIXELS_PER_RESULT = 4;

  // field widths
  localparam int PIXEL_W  = 8;
  localparam int COUNT_W  = 3;
  localparam int SIZE_W   = 9;
  localparam int NUM_PIX  = 4;
  localparam int TDATA_W  = 40;
  localparam int TUSER_W  = 2;

  // configuration register indexes and reset values
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;
  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 9'd152;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 9'd112;

  // header byte decoding
  localparam logic [7:0] REPEAT_HDR_MAX = 8'h7F;
  localparam logic [8:0] LITERAL_BASE   = 9'h100;

  // tuser bit positions
  localparam int USER_EOI = 0;
  localparam int USER_OVR = 1;

  // decode phase of the byte stream
  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LITERAL = 2'd1,
    PH_VALUE   = 2'd2
  } phase_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_READ  = 2'd1,
    ST_WRITE = 2'd2,
    ST_EMIT  = 2'd3
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic take;   // input byte accepted this cycle
    logic rd;     // read line store at current column
    logic wr;     // decode one pixel and write it back
    logic emit;   // move the pixel group to the output register
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic starts_run;  // next accepted byte produces pixels
    logic emit_now;    // pixel being written closes a group
    logic run_done;    // the run has no pixels left
    logic out_free;    // output register can take a group
  } sts_t;

  // pixels per result, values outside one to four taken as four
  function automatic logic [COUNT_W-1:0] group_size(input int p);
    logic [COUNT_W-1:0] g;
    g = (p < 1 || p > NUM_PIX) ? COUNT_W'(NUM_PIX) : COUNT_W'(p);
    return g;
  endfunction

endpackage

FILE: rtl/rle_xor_row_image_decoder.sv
// Run-length image decoder with row xor. A header byte is only accepted. A
// literal byte passes through accept, line store read, pixel write and emit.
// A repeat value of n pixels is accepted once; then each pixel costs a read
// followed by a write on the single-port line store, and each result of up to
// G pixels, G being the pixels per result, an emit into the output register.
// Dropped literal bytes past the image end are only accepted. A result waiting in
// the output register blocks only the next emit. The line store needs no
// clearing pass after reset.
// top level: joins rxid_ctrl and rxid_datapath; depends on rxid_pkg
module rle_xor_row_image_decoder #(
  parameter int MAX_WIDTH         = rxid_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT        = rxid_pkg::DEF_MAX_HEIGHT,
  parameter int PIXELS_PER_RESULT = rxid_pkg::DEF_PIXELS_PER_RESULT
) (
  input  logic                          clk,
  input  logic                          rst,
  // input byte stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // in_byte
  // decoded pixel results
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // pixel_a, pixel_b, pixel_c, pixel_d, pixel_count, zero fill
  output logic [rxid_pkg::TDATA_W-1:0]  m_tdata,
  output logic                          m_tlast,   // last_of_run
  // end_of_image, overrun
  output logic [rxid_pkg::TUSER_W-1:0]  m_tuser,
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [rxid_pkg::SIZE_W-1:0]   cfg_data
);
  import rxid_pkg::*;

  localparam logic [COUNT_W-1:0] GROUP = group_size(PIXELS_PER_RESULT);

  cmd_t cmd;
  sts_t sts;

  // configuration always taken
  assign cfg_ready = 1'b1;

  rxid_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rxid_datapath #(
    .MAX_WIDTH         (MAX_WIDTH),
    .MAX_HEIGHT        (MAX_HEIGHT),
    .PIXELS_PER_RESULT (PIXELS_PER_RESULT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_tdata (m_tdata),
    .out_last  (m_tlast),
    .out_user  (m_tuser)
  );

`ifndef SYNTHESIS
  // a result holds between one and a full group of pixels
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[34:32] != '0) && (m_tdata[34:32] <= GROUP))
    else $error("pixel count out of range");

  // overrun only comes with the end of the image
  a_ovr_eoi: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[USER_OVR] |-> m_tuser[USER_EOI])
    else $error("overrun without end of image");

  // the end of the image closes the run
  a_eoi_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[USER_EOI] |-> m_tlast)
    else $error("end of image not last of run");

  // no new byte taken while a group is being emitted
  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !s_tready)
    else $error("input accepted during emit");
`endif

endmodule

FILE: rtl/rxid_ctrl.sv
// controller state machine: sequences accept, line store read, pixel write, emit
// depends on rxid_pkg
module rxid_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  rxid_pkg::sts_t sts,
  output rxid_pkg::cmd_t cmd
);
  import rxid_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && sts.starts_run) state_next = ST_READ;
      end
      ST_READ: begin
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        state_next = sts.emit_now ? ST_EMIT : ST_READ;
      end
      ST_EMIT: begin
        if (sts.out_free) state_next = sts.run_done ? ST_IDLE : ST_READ;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_READ: begin
        cmd.rd = 1'b1;
      end
      ST_WRITE: begin
        cmd.wr = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

FILE: rtl/rxid_datapath.sv
// datapath: header decode, line store, row xor, pixel grouping, output register
// depends on rxid_pkg
module rxid_datapath #(
  parameter int MAX_WIDTH         = rxid_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT        = rxid_pkg::DEF_MAX_HEIGHT,
  parameter int PIXELS_PER_RESULT = rxid_pkg::DEF_PIXELS_PER_RESULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [rxid_pkg::PIXEL_W-1:0]  in_data,
  input  rxid_pkg::cmd_t                cmd,
  output rxid_pkg::sts_t                sts,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [rxid_pkg::SIZE_W-1:0]   cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rxid_pkg::TDATA_W-1:0]  out_tdata,
  output logic                          out_last,
  output logic [rxid_pkg::TUSER_W-1:0]  out_user
);
  import rxid_pkg::*;

  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CCMPW = (CW + 1 > SIZE_W) ? CW + 1 : SIZE_W;
  localparam int RCMPW = (RW + 1 > SIZE_W) ? RW + 1 : SIZE_W;
  localparam logic [COUNT_W-1:0] GROUP = group_size(PIXELS_PER_RESULT);

  // configuration registers
  logic [SIZE_W-1:0] image_width;
  logic [SIZE_W-1:0] image_height;

  // stream decode state
  phase_t           phase;
  logic [7:0]       remaining;
  logic             dropping;

  // image position
  logic [CW-1:0]    column;
  logic [RW-1:0]    row;
  logic             first_row;

  // current run
  logic [7:0]       run_byte;
  logic [7:0]       pix_left;
  logic             lit_more;
  logic             run_done;

  // pixel group under assembly
  logic [PIXEL_W-1:0] grp [NUM_PIX];
  logic [COUNT_W-1:0] cnt;
  logic               grp_eoi;
  logic               grp_ovr;

  // line store
  logic [PIXEL_W-1:0] line_mem [MAX_WIDTH];
  logic [PIXEL_W-1:0] rd_data;

  logic [CCMPW-1:0]   w_eff;
  logic [RCMPW-1:0]   h_eff;
  logic [CCMPW-1:0]   col_inc;
  logic [RCMPW-1:0]   row_inc;
  logic               row_end;
  logic               img_end;
  logic [PIXEL_W-1:0] pix;
  logic [7:0]         rem_dec;
  logic [PIXEL_W-1:0] px_out [NUM_PIX];

  // effective sizes: zero taken as one, saturated at the maximum
  always_comb begin
    if (image_width == '0) begin
      w_eff = CCMPW'(1);
    end else if (CCMPW'(image_width) > CCMPW'(MAX_WIDTH)) begin
      w_eff = CCMPW'(MAX_WIDTH);
    end else begin
      w_eff = CCMPW'(image_width);
    end
    if (image_height == '0) begin
      h_eff = RCMPW'(1);
    end else if (RCMPW'(image_height) > RCMPW'(MAX_HEIGHT)) begin
      h_eff = RCMPW'(MAX_HEIGHT);
    end else begin
      h_eff = RCMPW'(image_height);
    end
  end

  // position step and pixel value
  assign col_inc = CCMPW'(column) + CCMPW'(1);
  assign row_inc = RCMPW'(row) + RCMPW'(1);
  assign row_end = (col_inc >= w_eff);
  assign img_end = row_end && (row_inc >= h_eff);
  assign pix     = first_row ? run_byte : (run_byte ^ rd_data);
  assign rem_dec = remaining - 8'd1;

  // status to controller
  always_comb begin
    sts.starts_run = ((phase == PH_LITERAL) && !dropping) || (phase == PH_VALUE);
    sts.emit_now   = img_end || ((cnt + COUNT_W'(1)) == GROUP) || (pix_left == 8'd1);
    sts.run_done   = run_done;
    sts.out_free   = !out_valid || out_ready;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_IMAGE_WIDTH) begin
        image_width <= cfg_data;
      end
      if (cfg_index == REG_IMAGE_HEIGHT) begin
        image_height <= cfg_data;
      end
    end
  end

  // byte stream decode on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEADER;
      remaining <= '0;
      dropping  <= 1'b0;
    end else begin
      if (cmd.take) begin
        case (phase)
          PH_LITERAL: begin
            remaining <= rem_dec;
            if (rem_dec == 8'd0) begin
              phase <= PH_HEADER;
              if (dropping) dropping <= 1'b0;
            end
          end
          PH_VALUE: begin
            remaining <= '0;
            phase     <= PH_HEADER;
          end
          default: begin
            dropping <= 1'b0;
            if (in_data > REPEAT_HDR_MAX) begin
              remaining <= 8'(LITERAL_BASE - {1'b0, in_data});
              phase     <= PH_LITERAL;
            end else begin
              remaining <= in_data + 8'd1;
              phase     <= PH_VALUE;
            end
          end
        endcase
      end
      // image ended inside a literal run: drop the rest of it
      if (cmd.wr && img_end && lit_more) begin
        dropping <= 1'b1;
      end
    end
  end

  // run setup
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      run_byte <= in_data;
      if (phase == PH_VALUE) begin
        pix_left <= remaining;
        lit_more <= 1'b0;
      end else begin
        pix_left <= 8'd1;
        lit_more <= (rem_dec != 8'd0);
      end
    end else if (cmd.wr) begin
      pix_left <= pix_left - 8'd1;
    end
  end

  // image position
  always_ff @(posedge clk) begin
    if (rst) begin
      column    <= '0;
      row       <= '0;
      first_row <= 1'b1;
    end else if (cmd.wr) begin
      if (row_end) begin
        column    <= '0;
        first_row <= 1'b0;
        if (img_end) begin
          row       <= '0;
          first_row <= 1'b1;
        end else begin
          row <= row + RW'(1);
        end
      end else begin
        column <= column + CW'(1);
      end
    end
  end

  // line store, read then write of the same column
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data <= line_mem[column];
    end
    if (cmd.wr) begin
      line_mem[column] <= pix;
    end
  end

  // pixel group assembly
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      run_done <= 1'b0;
      grp_eoi  <= 1'b0;
      grp_ovr  <= 1'b0;
    end else if (cmd.wr) begin
      grp[cnt[1:0]] <= pix;
      cnt           <= cnt + COUNT_W'(1);
      run_done      <= img_end || (pix_left == 8'd1);
      grp_eoi       <= img_end;
      grp_ovr       <= img_end && ((pix_left != 8'd1) || lit_more);
    end else if (cmd.emit) begin
      cnt <= '0;
    end
  end

  // unused pixel slots read as zero
  always_comb begin
    for (int j = 0; j < NUM_PIX; j++) begin
      px_out[j] = (COUNT_W'(j) < cnt) ? grp[j] : '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_tdata <= {(TDATA_W - NUM_PIX * PIXEL_W - COUNT_W)'(0), cnt,
                    px_out[3], px_out[2], px_out[1], px_out[0]};
      out_last  <= run_done;
      out_user[USER_EOI] <= grp_eoi;
      out_user[USER_OVR] <= grp_ovr;
    end
  end

endmodule

FILE: verif/rle_xor_row_image_decoder_test.sv
// self-checking testbench for the run-length row-xor image decoder
// predicts every pixel group in a scoreboard class, drives stream and config ports
// depends on rxid_pkg and rle_xor_row_image_decoder
module rle_xor_row_image_decoder_test;
  import rxid_pkg::*;

  localparam int LINE_MAX    = DEF_MAX_WIDTH;
  localparam int ROWS_MAX    = DEF_MAX_HEIGHT;
  localparam int GROUP       = DEF_PIXELS_PER_RESULT;
  localparam int QUIET_LIMIT = 1000;
  localparam int COL_W       = $clog2(LINE_MAX);

  // one expected output request
  typedef struct packed {
    logic [NUM_PIX-1:0][PIXEL_W-1:0] pix;
    logic [COUNT_W-1:0]              count;
    logic                            last_of_run;
    logic                            end_of_image;
    logic                            overrun;
  } pixel_group_t;

  // decoder state mirror and queue of pixel groups still to come
  class decoded_pixel_scoreboard;
    logic [SIZE_W-1:0]  width_reg;
    logic [SIZE_W-1:0]  height_reg;
    logic [PIXEL_W-1:0] line_store [LINE_MAX];
    int                 written_hi;
    int                 column;
    int                 row;
    phase_t             phase;
    int                 remaining;
    bit                 first_row;
    bit                 dropping;
    pixel_group_t       pending_groups [$];
    int                 errors;

    function new();
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      foreach (line_store[i]) line_store[i] = '0;
      written_hi = 0;
      column     = 0;
      row        = 0;
      phase      = PH_HEADER;
      remaining  = 0;
      first_row  = 1'b1;
      dropping   = 1'b0;
      errors     = 0;
    endfunction

    function void write_reg(logic idx, logic [SIZE_W-1:0] value);
      if (idx == REG_IMAGE_WIDTH) width_reg = value;
      else height_reg = value;
    endfunction

    function int clamp_size(logic [SIZE_W-1:0] v, int limit);
      if (v == 0) return 1;
      return (v > limit) ? limit : int'(v);
    endfunction

    // a width is safe when no later row reads a column never written
    function bit width_is_safe(logic [SIZE_W-1:0] w);
      int need;
      if (first_row) return 1'b1;
      need = clamp_size(w, LINE_MAX);
      if (column + 1 > need) need = column + 1;
      return need <= written_hi;
    endfunction

    function int pending();
      return pending_groups.size();
    endfunction

    // one pixel through the row xor, stepping column, row and image
    function logic [PIXEL_W-1:0] xor_decode_pixel(logic [PIXEL_W-1:0] b, output bit img_end);
      logic [PIXEL_W-1:0] v;
      v = b;
      if (!first_row) v = b ^ line_store[COL_W'(column)];
      line_store[COL_W'(column)] = v;
      if (column + 1 > written_hi) written_hi = column + 1;
      img_end = 1'b0;
      column++;
      if (column >= clamp_size(width_reg, LINE_MAX)) begin
        column    = 0;
        row++;
        first_row = 1'b0;
        if (row >= clamp_size(height_reg, ROWS_MAX)) begin
          row       = 0;
          first_row = 1'b1;
          img_end   = 1'b1;
        end
      end
      return v;
    endfunction

    // accepted input byte: work out the pixel groups it causes
    function void note_byte(logic [7:0] b);
      pixel_group_t g;
      bit           img_end;
      bit           last;
      int           n;
      int           cnt;
      g = '0;
      case (phase)
        PH_LITERAL: begin
          remaining--;
          last = (remaining == 0);
          if (last) phase = PH_HEADER;
          if (dropping) begin
            if (last) dropping = 1'b0;
            return;
          end
          g.pix[0]       = xor_decode_pixel(b, img_end);
          g.count        = COUNT_W'(1);
          g.last_of_run  = 1'b1;
          g.end_of_image = img_end;
          g.overrun      = img_end && !last;
          pending_groups.push_back(g);
          if (img_end && !last) dropping = 1'b1;
        end
        PH_VALUE: begin
          n         = remaining;
          remaining = 0;
          phase     = PH_HEADER;
          cnt       = 0;
          for (int i = 0; i < n; i++) begin
            g.pix[cnt] = xor_decode_pixel(b, img_end);
            cnt++;
            if (img_end) begin
              g.count        = COUNT_W'(cnt);
              g.last_of_run  = 1'b1;
              g.end_of_image = 1'b1;
              g.overrun      = (i + 1) < n;
              pending_groups.push_back(g);
              return;
            end
            if (cnt == GROUP) begin
              g.count       = COUNT_W'(cnt);
              g.last_of_run = (i + 1) == n;
              pending_groups.push_back(g);
              g   = '0;
              cnt = 0;
            end
          end
          if (cnt > 0) begin
            g.count       = COUNT_W'(cnt);
            g.last_of_run = 1'b1;
            pending_groups.push_back(g);
          end
        end
        default: begin
          // header byte: literal count or repeat count
          dropping = 1'b0;
          if (b > REPEAT_HDR_MAX) begin
            remaining = int'(LITERAL_BASE - b);
            phase     = PH_LITERAL;
          end else begin
            remaining = b + 1;
            phase     = PH_VALUE;
          end
        end
      endcase
    endfunction

    function void compare_field(string name, logic [PIXEL_W-1:0] want, logic [PIXEL_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    // accepted output request against the oldest expectation
    function void check_group(logic [TDATA_W-1:0] data, logic last,
                              logic [TUSER_W-1:0] user);
      pixel_group_t want;
      string        names [NUM_PIX] = '{"pixel_a", "pixel_b", "pixel_c", "pixel_d"};
      if (pending_groups.size() == 0) begin
        $error("result with no expectation waiting: tdata %h", data);
        errors++;
        return;
      end
      want = pending_groups.pop_front();
      for (int k = 0; k < NUM_PIX; k++)
        compare_field(names[k], want.pix[k], data[PIXEL_W*k +: PIXEL_W]);
      compare_field("pixel_count", PIXEL_W'(want.count),
                    PIXEL_W'(data[PIXEL_W*NUM_PIX +: COUNT_W]));
      compare_field("last_of_run", PIXEL_W'(want.last_of_run), PIXEL_W'(last));
      compare_field("end_of_image", PIXEL_W'(want.end_of_image), PIXEL_W'(user[USER_EOI]));
      compare_field("overrun", PIXEL_W'(want.overrun), PIXEL_W'(user[USER_OVR]));
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [7:0]         s_tdata;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  logic               m_tlast;
  logic [TUSER_W-1:0] m_tuser;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_index;
  logic [SIZE_W-1:0]  cfg_data;

  decoded_pixel_scoreboard sb;
  int burst_left;
  bit tx_active;
  int rx_mode = 0;
  int rx_hold = 0;
  int rx_tick = 0;
  int quiet_cycles = 0;

  rle_xor_row_image_decoder DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver: check each accepted request, stall in changing modes
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_group(m_tdata, m_tlast, m_tuser);
    rx_tick++;
    if (rx_tick % 97 == 0) rx_mode = $urandom_range(0, 2);
    if (rx_hold > 0) begin
      rx_hold--;
      m_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        default: begin
          if ($urandom_range(0, 15) == 0) begin
            rx_hold = $urandom_range(4, 24);
            m_tready <= 1'b0;
          end else begin
            m_tready <= 1'b1;
          end
        end
      endcase
    end
  end

  // watchdog on cycles with no request accepted anywhere
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one input byte; valid stays high within a burst, drops for a gap after it
  task automatic send_byte(input logic [7:0] b);
    s_tvalid  <= 1'b1;
    s_tdata   <= b;
    tx_active = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_byte(b);
    burst_left--;
    if (burst_left <= 0) begin
      s_tvalid  <= 1'b0;
      tx_active = 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
    end
  endtask

  // stop sending, wait for every expected group, then let the block settle
  task automatic end_phase();
    if (tx_active) begin
      s_tvalid  <= 1'b0;
      tx_active = 1'b0;
    end
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [SIZE_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  // width kept as it is where the new one would read unwritten columns
  task automatic configure(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
    if (!sb.width_is_safe(w)) w = sb.width_reg;
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  // mostly well-formed runs with random content, some cut short, some noise
  task automatic random_stream(input int target);
    int         sent;
    int         n;
    int         keep;
    int         sel;
    logic [7:0] hdr;
    sent = 0;
    while (sent < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        sel  = $urandom_range(0, 99);
        n    = (sel < 70) ? $urandom_range(1, 4) : (sel < 97) ? $urandom_range(5, 32) : 128;
        keep = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : n;
        send_byte(8'(LITERAL_BASE - n));
        for (int i = 0; i < keep; i++) send_byte(8'($urandom_range(0, 255)));
        sent += keep + 1;
      end else if (sel < 88) begin
        sel = $urandom_range(0, 99);
        hdr = (sel < 60) ? 8'($urandom_range(0, 7)) :
              (sel < 90) ? 8'($urandom_range(0, 127)) : REPEAT_HDR_MAX;
        send_byte(hdr);
        send_byte(8'($urandom_range(0, 255)));
        sent += 2;
      end else begin
        send_byte(8'($urandom_range(0, 255)));
        sent++;
      end
    end
  endtask

  initial begin
    logic [SIZE_W-1:0] sizes [6][2];
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
    sizes = '{'{9'd3, 9'd2}, '{9'd0, 9'd0}, '{9'd511, 9'd2},
              '{9'd256, 9'd511}, '{9'd1, 9'd256}, '{9'd7, 9'd1}};
    sb = new();
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= '0;
    tx_active  = 1'b0;
    burst_left = $urandom_range(1, 8);
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // 2x2 image: literal and repeat runs, exact end, repeat and literal past the end
    configure(9'd2, 9'd2);
    send_byte(8'hFF); send_byte(8'h00);
    send_byte(8'hFE); send_byte(8'hFF); send_byte(8'h5A);
    send_byte(8'h00); send_byte(8'hFF);
    send_byte(8'h7F); send_byte(8'h81);
    send_byte(8'hFA);
    send_byte(8'h11); send_byte(8'h22); send_byte(8'h33);
    send_byte(8'h44); send_byte(8'h55); send_byte(8'h66);
    end_phase();

    // zero sizes read as one: every pixel ends an image
    configure(9'd0, 9'd0);
    send_byte(8'h01); send_byte(8'h33);
    end_phase();

    // width shrunk in the middle of a row ends that row at once
    configure(9'd8, 9'd4);
    send_byte(8'h05); send_byte(8'h11);
    send_byte(8'h07); send_byte(8'h22);
    end_phase();
    configure(9'd3, 9'd4);
    send_byte(8'h00); send_byte(8'h44);
    end_phase();

    // random phases, extremes first, then mostly small random sizes
    for (int p = 0; p < 8; p++) begin
      if (p < 6) begin
        w = sizes[p][0];
        h = sizes[p][1];
      end else begin
        w = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 511)) : 9'($urandom_range(1, 12));
        h = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 511)) : 9'($urandom_range(1, 6));
      end
      configure(w, h);
      random_stream(37);
      end_phase();
    end

    repeat (16) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: rle_xor_row_image_decoder.f
rtl/rxid_pkg.sv
rtl/rxid_ctrl.sv
rtl/rxid_datapath.sv
rtl/rle_xor_row_image_decoder.sv
verif/rle_xor_row_image_decoder_test.sv
